@@ src/tkm_pkg.sv @@
`default_nettype none
// ============================================================================
// tkm_pkg
// Shared types and constants of the trie keyword matcher
// ============================================================================
package tkm_pkg;

    // transaction function codes, carried on tuser of the input side
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_MATCH  = 2'd1;
    localparam logic [1:0] FUNC_RESET  = 2'd2;

    // whitespace characters that end a match run
    localparam logic [6:0] CH_SPACE = 7'd32;
    localparam logic [6:0] CH_CR    = 7'd13;
    localparam logic [6:0] CH_LF    = 7'd10;
    localparam logic [6:0] CH_TAB   = 7'd9;

    localparam int unsigned CH_W    = 7;
    localparam int unsigned TYPE_W  = 3;
    localparam int unsigned ID_W    = 9;
    localparam logic [ID_W-1:0] ID_MAX = 9'd511;

    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_REC
    } t_state;

endpackage : tkm_pkg
`default_nettype wire

@@ src/tkm_ram.sv @@
`default_nettype none
// ============================================================================
// tkm_ram
// Generic simple dual-port RAM, one write port and one registered read port
// ============================================================================
module tkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : tkm_ram
`default_nettype wire

@@ src/trie_keyword_matcher.sv @@
`default_nettype none
// ============================================================================
// trie_keyword_matcher
// Keyword trie over 7-bit characters with insert and match transactions
// ============================================================================
// Input channel (s side): tuser selects insert, match or cursor reset; tdata
// carries the character and the word type; tlast marks the last character
// of an inserted word. Output channel (m side): exactly one transaction per
// input, with the record id and type of the node reached in tdata and the
// matched and store-full flags in tuser.
// Inserts and matches of a non-blank character pass the idle, link and
// record states: the accept cycle in idle reads the child-link memory, the
// link state reads the node-record memory at the child, and the record state
// checks the link and writes back. Other transactions, whitespace matches
// included, go from idle straight to the record state. One item is in work
// at a time, set by the two dependent memory reads: no new item is taken
// until the record state has loaded the last result. Reset clears counters,
// cursors and the node count, and link entries are not swept; a link counts
// only if its child node was allocated since reset under the same parent and character.
// When the receiver stalls, the result waits in the output register and the
// block stops accepting once its next result is ready to be loaded.
module trie_keyword_matcher
    import tkm_pkg::*;
#(
    parameter int NODE_COUNT    = 256,
    parameter int ALPHABET_SIZE = 128,
    parameter int TYPE_COUNT    = 6
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    input  wire [S_DATA_W-1:0]    i_s_tdata,  // ch[6:0], word_type[9:7], zero pad
    input  wire [1:0]             i_s_tuser,  // func[1:0]
    input  wire                   i_s_tlast,  // last
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    output logic [M_DATA_W-1:0]   o_m_tdata,  // record_id[8:0], record_type[11:9], pad
    output logic [1:0]            o_m_tuser   // matched[0], store_full[1]
);

    localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NUW = $clog2(NODE_COUNT + 1);
    localparam int LD  = NODE_COUNT * ALPHABET_SIZE;
    localparam int AW  = $clog2(LD);
    localparam int TIW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
    localparam int RW  = CH_W + NW + TYPE_W + ID_W;

    // control state
    t_state              r_state, n_state;
    logic [NUW-1:0]      r_nodes_used, n_nodes_used;
    logic [NW-1:0]       r_ins_cur, n_ins_cur;
    logic [NW-1:0]       r_match_cur, n_match_cur;
    logic [ID_W-1:0]     r_cnt [TYPE_COUNT];
    logic [ID_W-1:0]     n_cnt [TYPE_COUNT];
    logic                r_out_valid, n_out_valid;

    // item payload
    logic [1:0]          r_func, n_func;
    logic [CH_W-1:0]     r_ch, n_ch;
    logic                r_last, n_last;
    logic [TYPE_W-1:0]   r_wtype, n_wtype;
    logic                r_lookup, n_lookup;
    logic [AW-1:0]       r_addr, n_addr;
    logic [NW-1:0]       r_parent, n_parent;
    logic [NW-1:0]       r_child, n_child;
    logic [M_DATA_W-1:0] r_out_data, n_out_data;
    logic [1:0]          r_out_user, n_out_user;

    // memory ports
    logic                link_we;
    logic [AW-1:0]       link_waddr, link_raddr;
    logic [NW-1:0]       link_wdata, link_rdata;
    logic                rec_we;
    logic [NW-1:0]       rec_waddr, rec_raddr;
    logic [RW-1:0]       rec_wdata, rec_rdata;

    // decode of the incoming transaction
    logic [CH_W-1:0]     in_ch;
    logic [TYPE_W-1:0]   in_wtype;
    logic                in_range, in_blank, in_lookup;
    logic [NW-1:0]       in_cursor;
    logic [AW-1:0]       in_addr;

    // decision signals
    logic [ID_W-1:0]     rec_id;
    logic [TYPE_W-1:0]   rec_type;
    logic [NW-1:0]       rec_parent;
    logic [CH_W-1:0]     rec_ch;
    logic                link_ok, store_full, type_ok, can_load;
    logic [3:0]          type_ext;
    logic [TIW-1:0]      type_idx;
    logic [ID_W-1:0]     cnt_cur, cnt_inc;
    logic [NW-1:0]       nxt;

    tkm_ram #(.WIDTH(NW), .DEPTH(LD)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    tkm_ram #(.WIDTH(RW), .DEPTH(NODE_COUNT)) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata)
    );

    assign in_ch     = i_s_tdata[CH_W-1:0];
    assign in_wtype  = i_s_tdata[CH_W+TYPE_W-1:CH_W];
    assign in_range  = {2'b00, in_ch} < 9'(ALPHABET_SIZE);
    assign in_blank  = (in_ch == CH_SPACE) || (in_ch == CH_CR) ||
                       (in_ch == CH_LF) || (in_ch == CH_TAB);
    assign in_lookup = in_range && ((i_s_tuser == FUNC_INSERT) ||
                       ((i_s_tuser == FUNC_MATCH) && !in_blank));
    assign in_cursor = (i_s_tuser == FUNC_INSERT) ? r_ins_cur : r_match_cur;
    assign in_addr   = AW'(in_cursor) * AW'(ALPHABET_SIZE) + AW'(in_ch);

    assign {rec_ch, rec_parent, rec_type, rec_id} = rec_rdata;

    // a stale link entry is rejected unless its child was allocated from here
    assign link_ok = r_lookup && (r_child != '0) && (NUW'(r_child) < r_nodes_used) &&
                     (rec_parent == r_parent) && (rec_ch == r_ch);
    assign store_full = r_nodes_used == NUW'(NODE_COUNT);
    assign type_ok    = {2'b00, r_wtype} < 5'(TYPE_COUNT);
    assign type_ext   = {1'b0, r_wtype};
    assign type_idx   = type_ext[TIW-1:0];
    assign cnt_cur    = r_cnt[type_idx];
    assign cnt_inc    = (cnt_cur < ID_MAX) ? cnt_cur + 1'b1 : cnt_cur;
    assign can_load   = !r_out_valid || i_m_tready;

    assign link_raddr = in_addr;
    assign rec_raddr  = (r_state == S_LINK) ? link_rdata : r_child;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_nodes_used <= NUW'(1);
            r_ins_cur    <= '0;
            r_match_cur  <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < TYPE_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_nodes_used <= n_nodes_used;
            r_ins_cur    <= n_ins_cur;
            r_match_cur  <= n_match_cur;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_ch       <= n_ch;
        r_last     <= n_last;
        r_wtype    <= n_wtype;
        r_lookup   <= n_lookup;
        r_addr     <= n_addr;
        r_parent   <= n_parent;
        r_child    <= n_child;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    always_comb begin
        n_state      = r_state;
        n_nodes_used = r_nodes_used;
        n_ins_cur    = r_ins_cur;
        n_match_cur  = r_match_cur;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_func       = r_func;
        n_ch         = r_ch;
        n_last       = r_last;
        n_wtype      = r_wtype;
        n_lookup     = r_lookup;
        n_addr       = r_addr;
        n_parent     = r_parent;
        n_child      = r_child;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        o_s_tready   = 1'b0;
        link_we      = 1'b0;
        link_waddr   = r_addr;
        link_wdata   = r_nodes_used[NW-1:0];
        rec_we       = 1'b0;
        rec_waddr    = r_child;
        rec_wdata    = rec_rdata;
        nxt          = r_child;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_func   = i_s_tuser;
                    n_ch     = in_ch;
                    n_last   = i_s_tlast;
                    n_wtype  = in_wtype;
                    n_lookup = in_lookup;
                    n_addr   = in_addr;
                    n_parent = in_cursor;
                    n_state  = in_lookup ? S_LINK : S_REC;
                end
            end
            S_LINK: begin
                n_child = link_rdata;
                n_state = S_REC;
            end
            S_REC: begin
                if (can_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_user  = '0;
                    case (r_func)
                        FUNC_INSERT: begin
                            if (r_lookup) begin
                                if (link_ok) begin
                                    nxt = r_child;
                                    rec_waddr = r_child;
                                    n_out_data = M_DATA_W'({rec_type, rec_id});
                                    if (r_last && rec_id == '0 && type_ok) begin
                                        n_cnt[type_idx] = cnt_inc;
                                        rec_we     = 1'b1;
                                        rec_wdata  = {rec_ch, rec_parent, r_wtype, cnt_inc};
                                        n_out_data = M_DATA_W'({r_wtype, cnt_inc});
                                    end
                                    n_ins_cur = r_last ? '0 : nxt;
                                end else if (store_full) begin
                                    n_ins_cur  = '0;
                                    n_out_user = 2'b10;
                                end else begin
                                    // allocate the next free node under this link
                                    nxt          = r_nodes_used[NW-1:0];
                                    link_we      = 1'b1;
                                    n_nodes_used = r_nodes_used + 1'b1;
                                    rec_we       = 1'b1;
                                    rec_waddr    = nxt;
                                    rec_wdata    = {r_ch, r_parent, {TYPE_W{1'b0}},
                                                    {ID_W{1'b0}}};
                                    if (r_last && type_ok) begin
                                        n_cnt[type_idx] = cnt_inc;
                                        rec_wdata  = {r_ch, r_parent, r_wtype, cnt_inc};
                                        n_out_data = M_DATA_W'({r_wtype, cnt_inc});
                                    end
                                    n_ins_cur = r_last ? '0 : nxt;
                                end
                            end
                        end
                        FUNC_MATCH: begin
                            if (link_ok) begin
                                n_match_cur = r_child;
                                n_out_data  = M_DATA_W'({rec_type, rec_id});
                                n_out_user  = 2'b01;
                            end else begin
                                n_match_cur = '0;
                            end
                        end
                        FUNC_RESET: begin
                            n_match_cur = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // node count stays between the root alone and a full store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nodes_used != '0) && (r_nodes_used <= NUW'(NODE_COUNT)))
        else $error("node count out of range");

    // every allocation advances the node count by exactly one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        link_we |=> (r_nodes_used == $past(r_nodes_used) + 1'b1))
        else $error("allocation did not advance node count");

    // both cursors always point at allocated nodes
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NUW'(r_ins_cur) < r_nodes_used) && (NUW'(r_match_cur) < r_nodes_used))
        else $error("cursor beyond allocated nodes");

    // a full-store result carries no record and no match
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[1]) |-> (!r_out_user[0] && r_out_data == '0))
        else $error("store-full result carries data");

endmodule : trie_keyword_matcher
`default_nettype wire

@@ tb/sv/tb_trie_keyword_matcher.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_trie_keyword_matcher
// Self-checking testbench for the trie keyword matcher
// ============================================================================
// A queue of character transactions feeds a clocked driver. Each accepted
// transaction also runs through a behavioral trie (links, node records, type
// counters, cursors) that predicts the result. A clocked monitor compares
// every output transaction with the oldest prediction. The stimulus inserts
// keywords, matches known words, prefixes and mangled words with whitespace
// or cursor resets in between, fills the node store, and mixes in raw noise.
// ============================================================================
module tb_trie_keyword_matcher;
    import tkm_pkg::*;

    localparam int NODES      = 256;
    localparam int ALPHA      = 128;
    localparam int TYPES      = 6;
    localparam int CYCLE_CAP  = 400000;
    localparam int CHUNK_LEN  = 450;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]        func;
        logic [CH_W-1:0]   ch;
        logic              last;
        logic [TYPE_W-1:0] wtype;
    } char_xact_t;

    typedef struct packed {
        logic              matched;
        logic [ID_W-1:0]   rec_id;
        logic [TYPE_W-1:0] rec_type;
        logic              full;
    } node_report_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_DATA_W-1:0]  i_s_tdata = '0;
    logic [1:0]           i_s_tuser = '0;
    logic                 i_s_tlast = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]  o_m_tdata;
    logic [1:0]           o_m_tuser;

    char_xact_t   pending_chars[$];
    node_report_t expected_reports[$];
    char_xact_t   driven_char = '0;
    string        known_words[$];
    int           send_idle_pct = 24;
    int           recv_idle_pct = 60;
    int           error_count = 0;
    int           cycle_count = 0;

    // behavioral trie
    logic [7:0]        trie_links[NODES*ALPHA];
    logic [TYPE_W-1:0] node_type[NODES];
    logic [ID_W-1:0]   node_id[NODES];
    logic [ID_W-1:0]   type_count[TYPES];
    int                nodes_alloc;
    int                match_node;
    int                insert_node;

    trie_keyword_matcher #(
        .NODE_COUNT    (NODES),
        .ALPHABET_SIZE (ALPHA),
        .TYPE_COUNT    (TYPES)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),  // ch[6:0], word_type[9:7], zero pad
        .i_s_tuser  (i_s_tuser),  // func[1:0]
        .i_s_tlast  (i_s_tlast),  // last
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),  // record_id[8:0], record_type[11:9], pad
        .o_m_tuser  (o_m_tuser)   // matched[0], store_full[1]
    );

    always #5 i_clk = ~i_clk;

    function automatic logic is_blank(logic [CH_W-1:0] c);
        return c == CH_SPACE || c == CH_CR || c == CH_LF || c == CH_TAB;
    endfunction

    function automatic void clear_trie();
        foreach (trie_links[k]) trie_links[k] = '0;
        foreach (node_type[k]) begin
            node_type[k] = '0;
            node_id[k] = '0;
        end
        foreach (type_count[k]) type_count[k] = '0;
        nodes_alloc = 1;
        match_node = 0;
        insert_node = 0;
    endfunction

    function automatic node_report_t walk_trie(char_xact_t x);
        node_report_t rep;
        int nxt;
        int slot;
        rep = '0;
        case (x.func)
            FUNC_INSERT: begin
                slot = insert_node * ALPHA + x.ch;
                nxt = trie_links[slot];
                if (nxt == 0 && nodes_alloc >= NODES) begin
                    insert_node = 0;
                    rep.full = 1'b1;
                    return rep;
                end
                if (nxt == 0) begin
                    nxt = nodes_alloc;
                    nodes_alloc++;
                    trie_links[slot] = nxt[7:0];
                end
                if (x.last) begin
                    if (node_id[nxt] == '0 && x.wtype < TYPES) begin
                        if (type_count[x.wtype] < ID_MAX)
                            type_count[x.wtype] = type_count[x.wtype] + 1'b1;
                        node_type[nxt] = x.wtype;
                        node_id[nxt] = type_count[x.wtype];
                    end
                    insert_node = 0;
                end else begin
                    insert_node = nxt;
                end
                rep.rec_id = node_id[nxt];
                rep.rec_type = node_type[nxt];
            end
            FUNC_MATCH: begin
                nxt = 0;
                if (!is_blank(x.ch))
                    nxt = trie_links[match_node * ALPHA + x.ch];
                match_node = nxt;
                if (nxt != 0) begin
                    rep.matched = 1'b1;
                    rep.rec_id = node_id[nxt];
                    rep.rec_type = node_type[nxt];
                end
            end
            FUNC_RESET: match_node = 0;
            default: ;
        endcase
        return rep;
    endfunction

    // driver: predicts each accepted transaction, then loads the next one
    always @(posedge i_clk) begin : drive_chars
        char_xact_t nx;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                expected_reports.push_back(walk_trie(driven_char));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_chars.size() != 0
                        && $urandom_range(99) >= send_idle_pct) begin
                    nx = pending_chars.pop_front();
                    driven_char <= nx;
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {{(S_DATA_W-CH_W-TYPE_W){1'b0}}, nx.wtype, nx.ch};
                    i_s_tuser <= nx.func;
                    i_s_tlast <= nx.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_reports
        node_report_t exp_rep;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result transaction: tdata %h tuser %h",
                       o_m_tdata, o_m_tuser);
                error_count++;
            end else begin
                exp_rep = expected_reports.pop_front();
                if (o_m_tuser[0] !== exp_rep.matched) begin
                    $error("matched: expected %0d, got %0d", exp_rep.matched, o_m_tuser[0]);
                    error_count++;
                end
                if (o_m_tdata[8:0] !== exp_rep.rec_id) begin
                    $error("record_id: expected %0d, got %0d", exp_rep.rec_id,
                           o_m_tdata[8:0]);
                    error_count++;
                end
                if (o_m_tdata[11:9] !== exp_rep.rec_type) begin
                    $error("record_type: expected %0d, got %0d", exp_rep.rec_type,
                           o_m_tdata[11:9]);
                    error_count++;
                end
                if (o_m_tuser[1] !== exp_rep.full) begin
                    $error("store_full: expected %0d, got %0d", exp_rep.full, o_m_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_char(logic [1:0] func, logic [CH_W-1:0] ch, logic last,
                              logic [TYPE_W-1:0] wtype);
        char_xact_t x;
        x.func = func;
        x.ch = ch;
        x.last = last;
        x.wtype = wtype;
        pending_chars.push_back(x);
    endtask

    function automatic string make_word(int len, bit wide);
        string w;
        w = "";
        for (int i = 0; i < len; i++) begin
            if (wide || $urandom_range(19) == 0)
                w = $sformatf("%s%c", w, 8'($urandom_range(126, 33)));
            else
                w = $sformatf("%s%c", w, 8'($urandom_range(102, 97)));
        end
        return w;
    endfunction

    task automatic queue_keyword(string w, logic [TYPE_W-1:0] wtype);
        for (int i = 0; i < w.len(); i++)
            queue_char(FUNC_INSERT, CH_W'(w[i]), i == w.len() - 1,
                       (i == w.len() - 1) ? wtype : TYPE_W'($urandom_range(7)));
        known_words.push_back(w);
    endtask

    task automatic queue_text(string w);
        for (int i = 0; i < w.len(); i++)
            queue_char(FUNC_MATCH, CH_W'(w[i]), 1'($urandom_range(1)),
                       TYPE_W'($urandom_range(7)));
    endtask

    function automatic logic [CH_W-1:0] pick_blank();
        case ($urandom_range(3))
            0: return CH_SPACE;
            1: return CH_CR;
            2: return CH_LF;
            default: return CH_TAB;
        endcase
    endfunction

    // well-formed keyword traffic with some noise mixed in
    task automatic queue_chunk(int fill_words);
        string w;
        int sel;
        int start_len;
        start_len = pending_chars.size();
        for (int i = 0; i < fill_words; i++)
            queue_keyword(make_word($urandom_range(8, 4), 1'b1),
                          TYPE_W'($urandom_range(5)));
        while (pending_chars.size() - start_len < CHUNK_LEN) begin
            sel = $urandom_range(99);
            if (sel < 30 || known_words.size() == 0) begin
                queue_keyword(make_word($urandom_range(5, 1), 1'b0),
                              TYPE_W'($urandom_range(9) == 0 ? $urandom_range(7, 6)
                                                               : $urandom_range(5)));
            end else if (sel < 75) begin
                w = known_words[$urandom_range(known_words.size() - 1)];
                case ($urandom_range(3))
                    0: w = w.substr(0, $urandom_range(w.len() - 1));
                    1: w.putc($urandom_range(w.len() - 1), 8'($urandom_range(102, 97)));
                    default: ;
                endcase
                queue_text(w);
                case ($urandom_range(7))
                    0, 1, 2, 3, 4: queue_char(FUNC_MATCH, pick_blank(), 1'b0, '0);
                    5: queue_char(FUNC_RESET, CH_W'($urandom_range(127)),
                                  1'($urandom_range(1)), TYPE_W'($urandom_range(7)));
                    default: ;
                endcase
            end else if (sel < 85) begin
                queue_text(make_word($urandom_range(6, 1), 1'b0));
            end else begin
                queue_char(2'($urandom_range(3)), CH_W'($urandom_range(127)),
                           1'($urandom_range(1)), TYPE_W'($urandom_range(7)));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || i_s_tvalid || expected_reports.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        clear_trie();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: records, repeats, type limits, character extremes
        queue_char(FUNC_INSERT, CH_W'("a"), 1'b0, 3'd7);
        queue_char(FUNC_INSERT, CH_W'("b"), 1'b1, 3'd0);
        queue_char(FUNC_INSERT, CH_W'("a"), 1'b0, 3'd0);
        queue_char(FUNC_INSERT, CH_W'("b"), 1'b1, 3'd3);  // word already has a record
        queue_char(FUNC_INSERT, CH_W'("a"), 1'b1, 3'd5);
        queue_char(FUNC_INSERT, CH_W'("c"), 1'b1, 3'd7);  // type out of range
        queue_char(FUNC_INSERT, 7'd127, 1'b1, 3'd6);
        queue_char(FUNC_INSERT, 7'd0, 1'b1, 3'd1);
        queue_char(FUNC_INSERT, CH_SPACE, 1'b1, 3'd2);
        queue_char(FUNC_MATCH, CH_W'("a"), 1'b0, 3'd0);
        queue_char(FUNC_MATCH, CH_W'("b"), 1'b1, 3'd7);
        queue_char(FUNC_MATCH, CH_SPACE, 1'b0, 3'd0);
        queue_char(FUNC_MATCH, CH_W'("a"), 1'b0, 3'd0);
        queue_char(FUNC_MATCH, CH_TAB, 1'b0, 3'd0);
        queue_char(FUNC_MATCH, CH_W'("b"), 1'b0, 3'd0);   // no link from the root
        queue_char(FUNC_MATCH, CH_W'("a"), 1'b0, 3'd0);
        queue_char(FUNC_RESET, 7'd127, 1'b1, 3'd7);
        queue_char(FUNC_MATCH, CH_W'("b"), 1'b0, 3'd0);
        queue_char(FUNC_SPARE, 7'd127, 1'b1, 3'd7);
        queue_char(FUNC_MATCH, CH_CR, 1'b0, 3'd0);
        queue_char(FUNC_MATCH, CH_LF, 1'b0, 3'd0);
        queue_char(FUNC_MATCH, 7'd0, 1'b0, 3'd0);
        queue_char(FUNC_MATCH, 7'd127, 1'b0, 3'd0);
        queue_char(FUNC_MATCH, CH_W'("c"), 1'b0, 3'd0);
        known_words.push_back("ab");
        known_words.push_back("a");

        queue_chunk(0);
        wait_drained();

        send_idle_pct = 60;
        recv_idle_pct = 24;
        queue_chunk(45);  // long wide-alphabet keywords exhaust the node store
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_chunk(0);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d result transactions never arrived", expected_reports.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
src/tkm_pkg.sv
src/tkm_ram.sv
src/trie_keyword_matcher.sv
tb/sv/tb_trie_keyword_matcher.sv
